// ===== rtl/core/dbbs_pkg.sv =====
// dbbs_pkg: shared codes, reset values and types for the disk bus byte sniffer
// no dependencies; imported by the result queue and the top level
package dbbs_pkg;

    // item modes
    localparam logic [1:0] MODE_WR_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_RD_SAMPLE  = 2'd1;
    localparam logic [1:0] MODE_REQ_CHANGE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_BYTE  = 2'd0;
    localparam logic [1:0] CFG_MIN_BITS   = 2'd1;
    localparam logic [1:0] CFG_PHASE_MASK = 2'd2;

    // channel codes
    localparam logic CH_WR = 1'b0;
    localparam logic CH_RD = 1'b1;

    // configuration reset values
    localparam logic [7:0]  RST_SYNC_BYTE  = 8'hC3;
    localparam logic [3:0]  RST_MIN_BITS   = 4'd10;
    localparam logic [15:0] RST_PHASE_MASK = 16'hCC00;

    // bit counter ceiling
    localparam logic [3:0] BIT_CNT_MAX = 4'd15;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // result fields other than the buffer position
    typedef struct packed {
        logic       channel;
        logic [7:0] data_byte;
        logic       stored;
        logic       end_of_packet;
        logic       overflow;
        logic       last;
    } t_res_meta;

    // results produced by one transfer, count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_res_meta  meta0;
        t_res_meta  meta1;
    } t_push;

endpackage

// ===== rtl/core/dbbs_if.sv =====
// dbbs_if: valid/ready channel interfaces of the disk bus byte sniffer
// input items, configuration writes and result items; no dependencies

// input item channel
interface dbbs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       sample_bit;
    logic       request_level;
    logic [3:0] phase_lines;

    modport source (output valid, output mode, output sample_bit,
                    output request_level, output phase_lines, input ready);
    modport sink   (input valid, input mode, input sample_bit,
                    input request_level, input phase_lines, output ready);
endinterface

// configuration write channel
interface dbbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// result item channel
interface dbbs_res_if #(
    parameter int POS_W = 11
);
    logic             valid;
    logic             ready;
    logic             channel;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] position;
    logic             stored;
    logic             end_of_packet;
    logic             overflow;
    logic             last;

    modport source (output valid, output channel, output data_byte, output position,
                    output stored, output end_of_packet, output overflow,
                    output last, input ready);
    modport sink   (input valid, input channel, input data_byte, input position,
                    input stored, input end_of_packet, input overflow,
                    input last, output ready);
endinterface

// ===== rtl/core/dbbs_res_fifo.sv =====
// dbbs_res_fifo: small result queue that takes up to two results per cycle while it has room
// for two, and hands out one per cycle while the receiver is ready; depends on dbbs_pkg
module dbbs_res_fifo import dbbs_pkg::*; #(
    parameter int POS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    input  logic [POS_W-1:0] i_pos0,
    input  logic [POS_W-1:0] i_pos1,
    output logic             o_in_ready,
    output logic             o_valid,
    input  logic             i_out_ready,
    output t_res_meta        o_meta,
    output logic [POS_W-1:0] o_pos
);

    t_res_meta              r_meta [QUEUE_DEPTH];
    logic [POS_W-1:0]       r_pos  [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] wr_ptr1;
    logic                   pop;

    // second write slot and read transfer
    assign wr_ptr1 = r_wr_ptr + QUEUE_PTR_W'(1);
    assign pop     = (r_count != '0) && i_out_ready;

    // room for a two-result burst
    assign o_in_ready = r_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign o_valid    = r_count != '0;
    assign o_meta     = r_meta[r_rd_ptr];
    assign o_pos      = r_pos[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_meta[r_wr_ptr] <= i_push.meta0;
            r_pos[r_wr_ptr]  <= i_pos0;
        end
        if (i_push.count == 2'd2) begin
            r_meta[wr_ptr1] <= i_push.meta1;
            r_pos[wr_ptr1]  <= i_pos1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(pop);
            r_count  <= r_count + QUEUE_CNT_W'(i_push.count) - QUEUE_CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // results only arrive while there is room for a burst
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_in_ready)
        else $error("push without room");

    // a lone read transfer drops the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.count == 2'd0) |=> r_count == $past(r_count) - QUEUE_CNT_W'(1))
        else $error("fill count lost track of a read");

    // a burst is a terminator pair with last only on the second
    a_burst_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd2) |-> (i_push.meta1.last && !i_push.meta0.last
            && i_push.meta0.end_of_packet && i_push.meta1.end_of_packet))
        else $error("bad terminator burst");
`endif

endmodule

// ===== rtl/core/disk_bus_byte_sniffer.sv =====
// disk_bus_byte_sniffer: byte deserializer for the write and read lines of a disk bus
// Results are written into the result queue on the transfer of the item that causes them.
// Throughput: one item per cycle; results leave one per cycle, while the receiver is ready,
// from a four-entry queue, and input is held off while more than two results wait there.
// Reset (synchronous, i_rst_n low) clears capture state and queue and loads the
// register defaults; no clearing pass is needed.
// depends on dbbs_pkg, dbbs_if and dbbs_res_fifo
module disk_bus_byte_sniffer import dbbs_pkg::*; #(
    parameter int PACKET_BYTES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dbbs_item_if.sink  i_item,
    dbbs_cfg_if.sink   i_cfg,
    dbbs_res_if.source o_result
);

    localparam int               CNT_W    = $clog2(PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PACKET_BYTES);

    // configuration
    logic [7:0]  r_sync_byte;
    logic [3:0]  r_min_bits;
    logic [15:0] r_phase_mask;

    // capture state
    logic             r_capture, n_capture;
    logic             r_prev_req, n_prev_req;
    logic             r_wr_prev, n_wr_prev;
    logic [7:0]       r_wr_win, n_wr_win;
    logic [7:0]       r_rd_win, n_rd_win;
    logic [3:0]       r_wr_bits, n_wr_bits;
    logic [3:0]       r_rd_bits, n_rd_bits;
    logic             r_wr_synced, n_wr_synced;
    logic             r_rd_synced, n_rd_synced;
    logic [CNT_W-1:0] r_wr_cnt, n_wr_cnt;
    logic [CNT_W-1:0] r_rd_cnt, n_rd_cnt;

    // datapath
    logic             in_xfer;
    logic             enabled;
    logic             is_rd;
    logic             is_sample;
    logic             wr_decoded;
    logic             sh_bit;
    logic [7:0]       sel_win;
    logic [3:0]       sel_bits;
    logic             sel_synced;
    logic [CNT_W-1:0] sel_cnt;
    logic [7:0]       win_sh;
    logic             byte_done;
    logic             synced_next;
    logic             sel_full;
    logic             sel_store;
    logic [3:0]       bits_next;
    logic             req_fall;
    logic             req_rise;
    logic             rd_full;
    logic             wr_full;

    // queue link
    t_push            push;
    logic [CNT_W-1:0] push_pos0;
    logic [CNT_W-1:0] push_pos1;
    logic             q_in_ready;
    t_res_meta        q_meta;
    logic [CNT_W-1:0] q_pos;

    // configuration writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte  <= RST_SYNC_BYTE;
            r_min_bits   <= RST_MIN_BITS;
            r_phase_mask <= RST_PHASE_MASK;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SYNC_BYTE:  r_sync_byte  <= i_cfg.data[7:0];
                CFG_MIN_BITS:   r_min_bits   <= i_cfg.data[3:0];
                CFG_PHASE_MASK: r_phase_mask <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // item decode
    assign i_item.ready = q_in_ready;
    assign in_xfer      = i_item.valid && i_item.ready;
    assign enabled      = r_phase_mask[i_item.phase_lines];
    assign is_rd        = i_item.mode == MODE_RD_SAMPLE;
    assign is_sample    = r_capture && (i_item.mode == MODE_WR_SAMPLE
                                        || i_item.mode == MODE_RD_SAMPLE);
    assign req_fall     = (i_item.mode == MODE_REQ_CHANGE) && !i_item.request_level
                          && r_prev_req;
    assign req_rise     = (i_item.mode == MODE_REQ_CHANGE) && i_item.request_level
                          && !r_prev_req && enabled;

    // write line is inverted, then a level change gives a one
    assign wr_decoded = ~i_item.sample_bit;
    assign sh_bit     = is_rd ? i_item.sample_bit : (wr_decoded ^ r_wr_prev);

    // shared shift unit on the selected channel
    assign sel_win    = is_rd ? r_rd_win    : r_wr_win;
    assign sel_bits   = is_rd ? r_rd_bits   : r_wr_bits;
    assign sel_synced = is_rd ? r_rd_synced : r_wr_synced;
    assign sel_cnt    = is_rd ? r_rd_cnt    : r_wr_cnt;

    assign win_sh      = {sel_win[6:0], sh_bit};
    assign byte_done   = win_sh[7];
    assign synced_next = sel_synced || (byte_done && win_sh == r_sync_byte
                                        && sel_bits > r_min_bits);
    assign sel_full    = sel_cnt == CNT_FULL;
    assign sel_store   = byte_done && synced_next && !sel_full;
    assign bits_next   = (sel_bits == BIT_CNT_MAX) ? sel_bits : sel_bits + 4'd1;

    assign rd_full = r_rd_cnt == CNT_FULL;
    assign wr_full = r_wr_cnt == CNT_FULL;

    // next state
    always_comb begin
        n_capture   = r_capture;
        n_prev_req  = r_prev_req;
        n_wr_prev   = r_wr_prev;
        n_wr_win    = r_wr_win;
        n_rd_win    = r_rd_win;
        n_wr_bits   = r_wr_bits;
        n_rd_bits   = r_rd_bits;
        n_wr_synced = r_wr_synced;
        n_rd_synced = r_rd_synced;
        n_wr_cnt    = r_wr_cnt;
        n_rd_cnt    = r_rd_cnt;
        if (in_xfer) begin
            priority if (is_sample) begin
                if (is_rd) begin
                    n_rd_win    = byte_done ? 8'd0 : win_sh;
                    n_rd_bits   = bits_next;
                    n_rd_synced = synced_next;
                    if (sel_store) begin
                        n_rd_cnt = r_rd_cnt + CNT_W'(1);
                    end
                end else begin
                    n_wr_prev   = wr_decoded;
                    n_wr_win    = byte_done ? 8'd0 : win_sh;
                    n_wr_bits   = bits_next;
                    n_wr_synced = synced_next;
                    if (sel_store) begin
                        n_wr_cnt = r_wr_cnt + CNT_W'(1);
                    end
                end
            end else if (i_item.mode == MODE_REQ_CHANGE) begin
                n_prev_req = i_item.request_level;
                if (req_fall) begin
                    n_wr_prev   = 1'b0;
                    n_wr_win    = 8'd0;
                    n_rd_win    = 8'd0;
                    n_wr_bits   = 4'd0;
                    n_rd_bits   = 4'd0;
                    n_wr_synced = 1'b0;
                    n_rd_synced = 1'b0;
                    n_wr_cnt    = '0;
                    n_rd_cnt    = '0;
                    if (enabled) begin
                        n_capture = 1'b1;
                    end
                end else if (req_rise) begin
                    n_capture = 1'b0;
                    if (!rd_full) begin
                        n_rd_cnt = r_rd_cnt + CNT_W'(1);
                    end
                    if (!wr_full) begin
                        n_wr_cnt = r_wr_cnt + CNT_W'(1);
                    end
                end
            end else begin
                n_capture = r_capture;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture   <= 1'b0;
            r_prev_req  <= 1'b1;
            r_wr_prev   <= 1'b0;
            r_wr_win    <= 8'd0;
            r_rd_win    <= 8'd0;
            r_wr_bits   <= 4'd0;
            r_rd_bits   <= 4'd0;
            r_wr_synced <= 1'b0;
            r_rd_synced <= 1'b0;
            r_wr_cnt    <= '0;
            r_rd_cnt    <= '0;
        end else begin
            r_capture   <= n_capture;
            r_prev_req  <= n_prev_req;
            r_wr_prev   <= n_wr_prev;
            r_wr_win    <= n_wr_win;
            r_rd_win    <= n_rd_win;
            r_wr_bits   <= n_wr_bits;
            r_rd_bits   <= n_rd_bits;
            r_wr_synced <= n_wr_synced;
            r_rd_synced <= n_rd_synced;
            r_wr_cnt    <= n_wr_cnt;
            r_rd_cnt    <= n_rd_cnt;
        end
    end

    // results of this transfer: one byte, or the read then write terminators
    always_comb begin
        push.count = 2'd0;
        push.meta0 = '0;
        push.meta1 = '0;
        push_pos0  = sel_cnt;
        push_pos1  = r_wr_cnt;
        if (in_xfer && is_sample && byte_done) begin
            push.count               = 2'd1;
            push.meta0.channel       = is_rd ? CH_RD : CH_WR;
            push.meta0.data_byte     = win_sh;
            push.meta0.stored        = sel_store;
            push.meta0.end_of_packet = 1'b0;
            push.meta0.overflow      = sel_full;
            push.meta0.last          = 1'b1;
        end else if (in_xfer && req_rise) begin
            push.count               = 2'd2;
            push.meta0.channel       = CH_RD;
            push.meta0.stored        = !rd_full;
            push.meta0.end_of_packet = 1'b1;
            push.meta0.overflow      = rd_full;
            push.meta0.last          = 1'b0;
            push.meta1.channel       = CH_WR;
            push.meta1.stored        = !wr_full;
            push.meta1.end_of_packet = 1'b1;
            push.meta1.overflow      = wr_full;
            push.meta1.last          = 1'b1;
            push_pos0                = r_rd_cnt;
        end
    end

    // result queue
    dbbs_res_fifo #(
        .POS_W (CNT_W)
    ) u_res_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pos0      (push_pos0),
        .i_pos1      (push_pos1),
        .o_in_ready  (q_in_ready),
        .o_valid     (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_meta      (q_meta),
        .o_pos       (q_pos)
    );

    // result channel
    assign o_result.channel       = q_meta.channel;
    assign o_result.data_byte     = q_meta.data_byte;
    assign o_result.position      = q_pos;
    assign o_result.stored        = q_meta.stored;
    assign o_result.end_of_packet = q_meta.end_of_packet;
    assign o_result.overflow      = q_meta.overflow;
    assign o_result.last          = q_meta.last;

endmodule
